/* sv/bto_pkg.sv */
// Shared definitions for the bitmap tree ordered set.
// Field widths, default universe size and the function codes.
// No dependencies.
`default_nettype none

package bto_pkg;

	localparam int unsigned KEY_W        = 16;
	localparam int unsigned FUNC_W       = 3;
	localparam int unsigned KEY_BITS_DEF = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 3'd0,
		FN_DELETE = 3'd1,
		FN_MIN    = 3'd2,
		FN_MAX    = 3'd3,
		FN_PRED   = 3'd4,
		FN_SUCC   = 3'd5,
		FN_MEMBER = 3'd6
	} func_t;

endpackage

`default_nettype wire

/* sv/bto_ram.sv */
// Generic simple dual-port RAM: one write and one registered read per cycle.
// Width and depth by parameter. No dependencies.
`default_nettype none

module bto_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 65536,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* sv/bitmap_tree_ordered_set.sv */
// Ordered set over 2^KEY_BITS keys held as a binary tree of occupancy bits.
// Depends on bto_pkg and bto_ram.
//
// A transaction is taken on a clock edge with start high and busy low. Results
// appear for one cycle with valid high and cannot be held off. After reset the
// tree RAM is cleared one row per cycle, all 2^KEY_BITS rows, with busy high.
// Timing is set by the tree RAM, which yields one tree level per cycle:
// min and max answer from registers and leave busy low; member reads the leaf;
// insert sets bits upward; delete clears them, then may descend to refresh min
// or max; predecessor and successor climb to the turning ancestor, then descend.
// The next transaction can be taken in the cycle the previous result shows.
`default_nettype none

module bitmap_tree_ordered_set
	import bto_pkg::*;
#(
	parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [KEY_W-1:0]  key,
	output logic                   valid,
	output logic                   found,
	output logic      [KEY_W-1:0]  result_key
);

	localparam int unsigned NW   = KEY_BITS + 1;
	localparam int unsigned ROWS = 2 ** KEY_BITS;

	typedef logic [KEY_BITS-1:0] kb_t;
	typedef logic [NW-1:0]       node_t;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_INS   = 7'b0000100,
		ST_DEL   = 7'b0001000,
		ST_CLIMB = 7'b0010000,
		ST_DESC  = 7'b0100000,
		ST_MEMB  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		DST_RESULT = 2'd0,
		DST_MIN    = 2'd1,
		DST_MAX    = 2'd2
	} dest_t;

	state_t state_q, state_d;
	node_t  node_q, node_d;
	kb_t    key_q, key_d;
	logic   carry_q, carry_d;
	logic   desc_max_q, desc_max_d;
	dest_t  dst_q, dst_d;
	kb_t    clr_q, clr_d;
	kb_t    min_q, min_d;
	kb_t    max_q, max_d;
	logic   nonempty_q, nonempty_d;
	logic   valid_q;
	logic   found_q;
	logic   [KEY_W-1:0] rkey_q;

	// RAM row r holds the bits of nodes 2r (bit 0) and 2r+1 (bit 1)
	logic       ram_we;
	kb_t        ram_waddr, ram_raddr;
	logic [1:0] ram_wdata, ram_rdata;

	logic  res_en, res_found;
	kb_t   res_key;
	kb_t   key_in;
	node_t leaf_in, parent, nxt, sib;
	logic  is_leaf, is_root, bit_sel, sib_bit, carry_nx, child_bit, hit;

	bto_ram #(
		.WIDTH (2),
		.DEPTH (ROWS)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign key_in    = kb_t'(key);
	assign leaf_in   = {1'b1, key_in};
	assign parent    = node_q >> 1;
	assign is_leaf   = node_q[KEY_BITS];
	assign is_root   = (node_q == node_t'(1));
	assign bit_sel   = ram_rdata[node_q[0]];
	assign sib_bit   = ram_rdata[~node_q[0]];
	assign carry_nx  = carry_q | sib_bit;
	assign child_bit = desc_max_q ? ram_rdata[1] : ~ram_rdata[0];
	assign nxt       = {node_q[KEY_BITS-1:0], child_bit};
	assign sib       = {node_q[KEY_BITS:1], ~node_q[0]};
	assign hit       = desc_max_q ? (node_q[0] & ram_rdata[0]) : (~node_q[0] & ram_rdata[1]);

	always_comb begin
		state_d    = state_q;
		node_d     = node_q;
		key_d      = key_q;
		carry_d    = carry_q;
		desc_max_d = desc_max_q;
		dst_d      = dst_q;
		clr_d      = clr_q;
		min_d      = min_q;
		max_d      = max_q;
		nonempty_d = nonempty_q;
		ram_we     = 1'b0;
		ram_waddr  = node_q[KEY_BITS:1];
		ram_wdata  = ram_rdata;
		ram_raddr  = '0;
		res_en     = 1'b0;
		res_found  = 1'b0;
		res_key    = '0;

		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + kb_t'(1);
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				if (start) begin
					key_d     = key_in;
					node_d    = leaf_in;
					ram_raddr = leaf_in[KEY_BITS:1];
					case (func_t'(func))
						FN_INSERT: state_d = ST_INS;
						FN_DELETE: begin
							carry_d = 1'b0;
							state_d = ST_DEL;
						end
						FN_MEMBER: state_d = ST_MEMB;
						FN_PRED: begin
							desc_max_d = 1'b1;
							state_d    = ST_CLIMB;
						end
						FN_SUCC: begin
							desc_max_d = 1'b0;
							state_d    = ST_CLIMB;
						end
						FN_MIN: begin
							res_en    = 1'b1;
							res_found = nonempty_q;
							res_key   = nonempty_q ? min_q : '0;
						end
						FN_MAX: begin
							res_en    = 1'b1;
							res_found = nonempty_q;
							res_key   = nonempty_q ? max_q : '0;
						end
						default: ;
					endcase
				end
			end

			// set bits upward; a bit already set means its ancestors are set too
			ST_INS: begin
				if (bit_sel) begin
					state_d = ST_IDLE;
				end else begin
					ram_we               = 1'b1;
					ram_wdata[node_q[0]] = 1'b1;
					if (is_leaf) begin
						nonempty_d = 1'b1;
						if (!nonempty_q || key_q < min_q) begin
							min_d = key_q;
						end
						if (!nonempty_q || key_q > max_q) begin
							max_d = key_q;
						end
					end
					if (is_root) begin
						state_d = ST_IDLE;
					end else begin
						node_d    = parent;
						ram_raddr = parent[KEY_BITS:1];
					end
				end
			end

			// clear bits upward until an occupied sibling keeps the parent set
			ST_DEL: begin
				if (is_leaf && !bit_sel) begin
					state_d = ST_IDLE;
				end else begin
					ram_we               = 1'b1;
					ram_wdata[node_q[0]] = carry_q;
					if (is_root) begin
						nonempty_d = 1'b0;
						min_d      = '0;
						max_d      = '0;
						state_d    = ST_IDLE;
					end else if (carry_nx) begin
						// set still holds other keys: refresh min or max if removed
						if (parent == node_t'(1)) begin
							// row 1 is being written now; the other half holds every key
							node_d    = sib;
							ram_raddr = sib[KEY_BITS-1:0];
						end else begin
							node_d    = node_t'(1);
							ram_raddr = kb_t'(1);
						end
						if (key_q == min_q) begin
							desc_max_d = 1'b0;
							dst_d      = DST_MIN;
							state_d    = ST_DESC;
						end else if (key_q == max_q) begin
							desc_max_d = 1'b1;
							dst_d      = DST_MAX;
							state_d    = ST_DESC;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						carry_d   = carry_nx;
						node_d    = parent;
						ram_raddr = parent[KEY_BITS:1];
					end
				end
			end

			ST_CLIMB: begin
				if (hit) begin
					if (sib[KEY_BITS]) begin
						res_en    = 1'b1;
						res_found = 1'b1;
						res_key   = sib[KEY_BITS-1:0];
						state_d   = ST_IDLE;
					end else begin
						node_d    = sib;
						ram_raddr = sib[KEY_BITS-1:0];
						dst_d     = DST_RESULT;
						state_d   = ST_DESC;
					end
				end else if (parent == node_t'(1)) begin
					res_en  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					node_d    = parent;
					ram_raddr = parent[KEY_BITS:1];
				end
			end

			ST_DESC: begin
				if (nxt[KEY_BITS]) begin
					case (dst_q)
						DST_MIN: min_d = nxt[KEY_BITS-1:0];
						DST_MAX: max_d = nxt[KEY_BITS-1:0];
						DST_RESULT: begin
							res_en    = 1'b1;
							res_found = 1'b1;
							res_key   = nxt[KEY_BITS-1:0];
						end
						default: ;
					endcase
					state_d = ST_IDLE;
				end else begin
					node_d    = nxt;
					ram_raddr = nxt[KEY_BITS-1:0];
				end
			end

			ST_MEMB: begin
				res_en    = 1'b1;
				res_found = bit_sel;
				res_key   = bit_sel ? key_q : '0;
				state_d   = ST_IDLE;
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			min_q      <= '0;
			max_q      <= '0;
			nonempty_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			min_q      <= min_d;
			max_q      <= max_d;
			nonempty_q <= nonempty_d;
			valid_q    <= res_en;
		end
	end

	always_ff @(posedge clk) begin
		node_q     <= node_d;
		key_q      <= key_d;
		carry_q    <= carry_d;
		desc_max_q <= desc_max_d;
		dst_q      <= dst_d;
		if (res_en) begin
			found_q <= res_found;
			rkey_q  <= KEY_W'(res_key);
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign valid      = valid_q;
	assign found      = found_q;
	assign result_key = rkey_q;

endmodule

`default_nettype wire

/* sv/bto_checker.sv */
// Port-level checks for the bitmap tree ordered set, bound to the top level.
// Depends on bto_pkg.
`default_nettype none

module bto_checker
	import bto_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [FUNC_W-1:0] func,
	input wire logic [KEY_W-1:0]  key,
	input wire logic              valid,
	input wire logic              found,
	input wire logic [KEY_W-1:0]  result_key
);

	logic take;
	assign take = start && !busy;

	// a miss carries a zero key
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !found |-> result_key == '0)
		else $error("result key not zero on a miss");

	// min and max are answered straight from registers
	a_minmax_now: assert property (@(posedge clk) disable iff (!arst_n)
		take && (func == FN_MIN || func == FN_MAX) |=> valid && !busy)
		else $error("min/max transaction not answered in one cycle");

	// tree walks hold the block busy
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && (func == FN_INSERT || func == FN_DELETE || func == FN_MEMBER ||
			func == FN_PRED || func == FN_SUCC) |=> busy && !valid)
		else $error("tree transaction did not hold busy");

	// every result ends its walk
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !busy)
		else $error("result shown while still busy");

	// a member hit echoes the queried key
	a_member_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(take && func == FN_MEMBER) ##2 (valid && found) |-> result_key == $past(key, 2))
		else $error("member test key not echoed");

endmodule

bind bitmap_tree_ordered_set bto_checker u_bto_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.func       (func),
	.key        (key),
	.valid      (valid),
	.found      (found),
	.result_key (result_key)
);

`default_nettype wire
